// ----- hw/rtl/cmwc4096_random_generator_defines.svh -----
// assertion helpers for the cmwc4096 generator
`ifndef CMWC4096_RANDOM_GENERATOR_DEFINES_SVH
`define CMWC4096_RANDOM_GENERATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define CMWC_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cmwc4096 same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define CMWC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cmwc4096 next-cycle check failed");

`endif

// ----- hw/rtl/cmwc_pkg.sv -----
package cmwc_pkg;

  localparam int WORD_W  = 32;
  localparam int CARRY_W = 19;
  localparam int MULT_W  = 15;
  localparam int PROD_W  = 48;
  localparam int CMD_W   = 2;

  localparam int LAG_DEPTH_DEFAULT = 4096;

  localparam logic [MULT_W-1:0]  MULT       = 15'd18782;
  localparam logic [CARRY_W-1:0] CARRY_INIT = 19'd362436;
  localparam logic [WORD_W-1:0]  GOLDEN     = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0]  COMPL_BASE = 32'hffff_fffe;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RAW    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESEED = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_MUL,
    ST_FIN,
    ST_MODULO,
    ST_FILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- hw/rtl/cmwc_if.sv -----
interface cmwc_in_if;
  logic                                valid;
  logic                                ready;
  logic [cmwc_pkg::CMD_W-1:0]          cmd;
  logic [cmwc_pkg::WORD_W-1:0]         seed;
  logic signed [cmwc_pkg::WORD_W-1:0]  range_low;
  logic signed [cmwc_pkg::WORD_W-1:0]  range_high;

  modport source (output valid, cmd, seed, range_low, range_high, input ready);
  modport sink   (input valid, cmd, seed, range_low, range_high, output ready);
endinterface

interface cmwc_out_if;
  logic                                valid;
  logic                                ready;
  logic [cmwc_pkg::WORD_W-1:0]         raw_word;
  logic signed [cmwc_pkg::WORD_W-1:0]  ranged_value;

  modport source (output valid, raw_word, ranged_value, input ready);
  modport sink   (input valid, raw_word, ranged_value, output ready);
endinterface

// ----- hw/rtl/cmwc_lag_mem.sv -----
module cmwc_lag_mem #(
  parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEFAULT,
  localparam int AW = $clog2(LAG_DEPTH)
) (
  input  logic                        clk,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [cmwc_pkg::WORD_W-1:0] rdata,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [cmwc_pkg::WORD_W-1:0] wdata
);

  logic [cmwc_pkg::WORD_W-1:0] mem [LAG_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/cmwc_mod_unit.sv -----
module cmwc_mod_unit (
  input  logic               clk,
  input  logic               rst,
  input  cmwc_pkg::div_req_t req,
  output cmwc_pkg::div_rsp_t rsp
);

  localparam int W  = cmwc_pkg::WORD_W;
  localparam int CW = $clog2(W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvd;
  logic [W-1:0]  divisor;

  logic [W:0]   shifted;
  logic [W+1:0] diff;

  // one quotient bit a cycle, restoring
  assign shifted = {rem, dvd[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      dvd     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[W-2:0], 1'b0};
      if (diff[W+1]) begin
        rem <= shifted[W-1:0];
      end else begin
        rem <= diff[W-1:0];
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ----- hw/rtl/cmwc4096_random_generator.sv -----
// steps: raw draw IDLE (table read), MUL, FIN, EMIT; empty range IDLE, EMIT; ranged draw IDLE,
// LIMIT, then MUL and FIN for each word drawn, then MODULO, EMIT (the bit-serial modulo unit runs twice)
// throughput: one item at a time, next beat taken once the item has left its last state;
// a reseed writes one table entry per cycle until the whole table is filled
// reset: synchronous rst clears control, carry 362436, position 4095; table undefined until
// a reseed fills it
`include "cmwc4096_random_generator_defines.svh"

module cmwc4096_random_generator #(
  parameter int LAG_DEPTH = cmwc_pkg::LAG_DEPTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  cmwc_in_if.sink    request,
  cmwc_out_if.source result
);

  localparam int W  = cmwc_pkg::WORD_W;
  localparam int AW = $clog2(LAG_DEPTH);
  localparam int CW = cmwc_pkg::CARRY_W;
  localparam int PW = cmwc_pkg::PROD_W;

  cmwc_pkg::state_t state, state_next;

  // generator state outside the table
  logic [CW-1:0] carry;
  logic [AW-1:0] position;
  logic [AW-1:0] pos_inc;

  // per-item registers
  logic          is_ranged;
  logic [W-1:0]  lo_q;
  logic [W-1:0]  span_q;
  logic [W-1:0]  limit_q;
  logic [W-1:0]  word_q;
  logic [PW-1:0] prod_q;
  logic [W-1:0]  res_word;
  logic [W-1:0]  res_value;

  // reseed fill
  logic [AW-1:0] fill_idx;
  logic [W-1:0]  fill_acc;
  logic [W-1:0]  w1, w2, w3;
  logic [W-1:0]  fill_value;

  // output register
  logic          out_valid;
  logic [W-1:0]  out_word;
  logic [W-1:0]  out_value;
  logic          slot_free;

  // memory port
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [W-1:0]  mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;

  cmwc_pkg::div_req_t div_req;
  cmwc_pkg::div_rsp_t div_rsp;

  logic          accept;
  logic          range_empty;
  logic [W-1:0]  req_span;
  logic          emit_load;

  // finishing arithmetic of one step
  logic [15:0]   c16;
  logic [W:0]    sum33;
  logic [W-1:0]  low;
  logic [16:0]   c17;
  logic [CW-1:0] carry_new;
  logic [W-1:0]  new_word;
  logic          reject;

  cmwc_lag_mem #(
    .LAG_DEPTH(LAG_DEPTH)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  cmwc_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign accept      = request.valid && request.ready;
  assign range_empty = (request.range_high <= request.range_low);
  assign req_span    = $unsigned(request.range_high) - $unsigned(request.range_low);
  assign slot_free   = !out_valid || result.ready;

  // table depth is a power of two, so the position wraps by itself
  assign pos_inc   = position + 1'b1;
  assign mem_raddr = pos_inc;

  // t = mult * x + carry was registered last cycle; fold the high word back in
  assign c16       = prod_q[PW-1:W];
  assign sum33     = {1'b0, prod_q[W-1:0]} + {17'b0, c16};
  assign low       = sum33[W-1:0] + W'(sum33[W]);
  assign c17       = {1'b0, c16} + 17'(sum33[W]);
  assign carry_new = CW'(c17);
  assign new_word  = cmwc_pkg::COMPL_BASE - low;
  assign reject    = is_ranged && (new_word < limit_q);

  // first three entries step by the golden constant, the rest use the xor recurrence
  assign fill_value = (fill_idx < AW'(3)) ? fill_acc
                    : (w3 ^ w2 ^ cmwc_pkg::GOLDEN ^ W'(fill_idx));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmwc_pkg::ST_IDLE: begin
        if (request.valid) begin
          unique case (request.cmd)
            cmwc_pkg::CMD_RAW:    state_next = cmwc_pkg::ST_MUL;
            cmwc_pkg::CMD_RANGE:  state_next = range_empty ? cmwc_pkg::ST_EMIT
                                                           : cmwc_pkg::ST_LIMIT;
            cmwc_pkg::CMD_RESEED: state_next = cmwc_pkg::ST_FILL;
            default:              state_next = cmwc_pkg::ST_IDLE;
          endcase
        end
      end
      cmwc_pkg::ST_LIMIT: begin
        if (div_rsp.done) begin
          state_next = cmwc_pkg::ST_MUL;
        end
      end
      cmwc_pkg::ST_MUL: begin
        state_next = cmwc_pkg::ST_FIN;
      end
      cmwc_pkg::ST_FIN: begin
        if (!is_ranged) begin
          state_next = cmwc_pkg::ST_EMIT;
        end else if (reject) begin
          state_next = cmwc_pkg::ST_MUL;
        end else begin
          state_next = cmwc_pkg::ST_MODULO;
        end
      end
      cmwc_pkg::ST_MODULO: begin
        if (div_rsp.done) begin
          state_next = cmwc_pkg::ST_EMIT;
        end
      end
      cmwc_pkg::ST_FILL: begin
        if (fill_idx == AW'(LAG_DEPTH - 1)) begin
          state_next = cmwc_pkg::ST_IDLE;
        end
      end
      cmwc_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = cmwc_pkg::ST_IDLE;
        end
      end
      default: state_next = cmwc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    request.ready    = 1'b0;
    mem_re           = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = position;
    mem_wdata        = new_word;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = span_q;
    emit_load        = 1'b0;
    unique case (state)
      cmwc_pkg::ST_IDLE: begin
        request.ready = 1'b1;
        if (request.valid) begin
          unique case (request.cmd)
            cmwc_pkg::CMD_RAW: begin
              mem_re = 1'b1;
            end
            cmwc_pkg::CMD_RANGE: begin
              // limit = (2^32 - span) mod span
              div_req.start    = !range_empty;
              div_req.dividend = W'(0) - req_span;
              div_req.divisor  = req_span;
            end
            default: ;
          endcase
        end
      end
      cmwc_pkg::ST_LIMIT: begin
        mem_re = div_rsp.done;
      end
      cmwc_pkg::ST_MUL: ;
      cmwc_pkg::ST_FIN: begin
        mem_we = 1'b1;
        // the next read is one entry ahead of this write, so no overlap
        mem_re = reject;
        if (is_ranged && !reject) begin
          div_req.start    = 1'b1;
          div_req.dividend = new_word;
        end
      end
      cmwc_pkg::ST_MODULO: ;
      cmwc_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_idx;
        mem_wdata = fill_value;
      end
      cmwc_pkg::ST_EMIT: begin
        emit_load = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // carry and position
  always_ff @(posedge clk) begin
    if (rst) begin
      carry    <= cmwc_pkg::CARRY_INIT;
      position <= AW'(LAG_DEPTH - 1);
    end else begin
      if (accept && request.cmd == cmwc_pkg::CMD_RESEED) begin
        carry    <= cmwc_pkg::CARRY_INIT;
        position <= AW'(LAG_DEPTH - 1);
      end else begin
        if (mem_re) begin
          position <= pos_inc;
        end
        if (state == cmwc_pkg::ST_FIN) begin
          carry <= carry_new;
        end
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      is_ranged <= (request.cmd == cmwc_pkg::CMD_RANGE);
      lo_q      <= $unsigned(request.range_low);
      span_q    <= req_span;
      fill_idx  <= '0;
      fill_acc  <= request.seed;
      // empty range: result straight from the bounds
      res_word  <= '0;
      res_value <= $unsigned(request.range_low);
    end
    if (state == cmwc_pkg::ST_LIMIT && div_rsp.done) begin
      limit_q <= div_rsp.rem;
    end
    if (state == cmwc_pkg::ST_MUL) begin
      prod_q <= PW'(mem_rdata) * PW'(cmwc_pkg::MULT) + PW'(carry);
    end
    if (state == cmwc_pkg::ST_FIN) begin
      word_q    <= new_word;
      res_word  <= new_word;
      res_value <= '0;
    end
    if (state == cmwc_pkg::ST_MODULO && div_rsp.done) begin
      res_word  <= word_q;
      res_value <= lo_q + div_rsp.rem;
    end
    if (state == cmwc_pkg::ST_FILL) begin
      fill_idx <= fill_idx + 1'b1;
      fill_acc <= fill_acc + cmwc_pkg::GOLDEN;
      w3       <= w2;
      w2       <= w1;
      w1       <= fill_value;
    end
  end

  // output register: a result beat waits here while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_word  <= res_word;
      out_value <= res_value;
    end
  end

  assign result.valid        = out_valid;
  assign result.raw_word     = out_word;
  assign result.ranged_value = $signed(out_value);

  `CMWC_ASSERT_NOW(a_no_write_in_idle, state == cmwc_pkg::ST_IDLE, !mem_we)
  `CMWC_ASSERT_NEXT(a_accept_leaves_idle, accept && request.cmd != cmwc_pkg::CMD_UNUSED, state != cmwc_pkg::ST_IDLE)
  `CMWC_ASSERT_NOW(a_mod_start_when_free, div_req.start, !div_rsp.busy)
  `CMWC_ASSERT_NEXT(a_emit_fills_slot, emit_load, result.valid && state == cmwc_pkg::ST_IDLE)

endmodule

// ----- tb/cmwc4096_draw_checker.sv -----
`timescale 1ns / 100ps

module cmwc4096_draw_checker (
  input  logic clk,
  input  logic rst,
  cmwc_in_if   req,
  cmwc_out_if  res,
  output int   fail_count,
  output int   pending
);
  import cmwc_pkg::*;

  localparam int POS_W = $clog2(LAG_DEPTH_DEFAULT);

  typedef struct packed {
    logic [WORD_W-1:0]        raw_word;
    logic signed [WORD_W-1:0] ranged_value;
  } draw_t;

  // shadow generator state
  logic [WORD_W-1:0]  lag_words [LAG_DEPTH_DEFAULT];
  logic [CARRY_W-1:0] carry_q;
  logic [POS_W-1:0]   pos_q;
  draw_t              draws_due [$];

  function automatic logic [WORD_W-1:0] next_lag_word();
    logic [63:0]       prod;
    logic [WORD_W-1:0] hi_part;
    logic [WORD_W-1:0] low;
    pos_q   = pos_q + 1'b1;
    prod    = 64'(MULT) * 64'(lag_words[pos_q]) + 64'(carry_q);
    hi_part = prod[63:32];
    low     = prod[31:0] + hi_part;
    // complement correction when the fold overflows
    if (low < hi_part) begin
      low     = low + 1;
      hi_part = hi_part + 1;
    end
    carry_q = hi_part[CARRY_W-1:0];
    lag_words[pos_q] = COMPL_BASE - low;
    return lag_words[pos_q];
  endfunction

  function automatic void fill_lag_table(input logic [WORD_W-1:0] seed);
    lag_words[0] = seed;
    lag_words[1] = seed + GOLDEN;
    lag_words[2] = seed + GOLDEN + GOLDEN;
    for (int k = 3; k < LAG_DEPTH_DEFAULT; k++)
      lag_words[k] = lag_words[k-3] ^ lag_words[k-2] ^ GOLDEN ^ WORD_W'(k);
    carry_q = CARRY_INIT;
    pos_q   = '1;
  endfunction

  function automatic draw_t ranged_draw(input logic signed [WORD_W-1:0] lo,
                                        input logic signed [WORD_W-1:0] hi);
    draw_t             d;
    logic [WORD_W-1:0] span;
    logic [WORD_W-1:0] floor_word;
    logic [WORD_W-1:0] word;
    if (hi <= lo) begin
      d.raw_word     = '0;
      d.ranged_value = lo;
      return d;
    end
    span       = $unsigned(hi) - $unsigned(lo);
    floor_word = (32'd0 - span) % span;
    word       = next_lag_word();
    while (word < floor_word)
      word = next_lag_word();
    d.raw_word     = word;
    d.ranged_value = $signed(word % span + $unsigned(lo));
    return d;
  endfunction

  always @(posedge clk) begin
    draw_t seen;
    draw_t due;
    if (rst) begin
      carry_q = CARRY_INIT;
      pos_q   = '1;
      draws_due.delete();
    end else begin
      // results first: a result beat never belongs to a request taken at the same edge
      if (res.valid && res.ready) begin
        seen.raw_word     = res.raw_word;
        seen.ranged_value = res.ranged_value;
        if (draws_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result raw_word %h ranged_value %0d", $time,
                   seen.raw_word, seen.ranged_value);
        end else begin
          due = draws_due.pop_front();
          if (seen.raw_word !== due.raw_word) begin
            fail_count++;
            $display("%0t: raw_word expected %h actual %h", $time,
                     due.raw_word, seen.raw_word);
          end
          if (seen.ranged_value !== due.ranged_value) begin
            fail_count++;
            $display("%0t: ranged_value expected %0d actual %0d", $time,
                     due.ranged_value, seen.ranged_value);
          end
        end
      end
      if (req.valid && req.ready) begin
        case (req.cmd)
          CMD_RAW: begin
            due.raw_word     = next_lag_word();
            due.ranged_value = '0;
            draws_due.push_back(due);
          end
          CMD_RANGE:  draws_due.push_back(ranged_draw(req.range_low, req.range_high));
          CMD_RESEED: fill_lag_table(req.seed);
          default: ;
        endcase
      end
    end
    pending = draws_due.size();
  end

endmodule

// ----- tb/tb_cmwc4096_random_generator.sv -----
`timescale 1ns / 100ps

module tb_cmwc4096_random_generator;
  import cmwc_pkg::*;

  // an honest run stays well under this limit, most of it table fills
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 300;
  // a table fill gives no result, so the tail is long enough to cover one
  localparam int DRAIN_CYCLES    = 5000;
  localparam int IDLE_PERCENT    = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  cmwc_in_if  req_if ();
  cmwc_out_if res_if ();

  int fail_count;
  int results_due;
  int cycle_count;

  // steady: neither side idles; hold_off_req: receiver parks ready low for a while
  bit steady;
  bit hold_off_req;

  cmwc4096_random_generator i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  cmwc4096_draw_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .res        (res_if),
    .fail_count (fail_count),
    .pending    (results_due)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random back-pressure, or one long hold-off counted here
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_if.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        res_if.ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // offer one request beat; entered and left at a falling edge
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] seed,
                       input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    // occasional gaps before the beat, never in the steady phase
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.cmd        = cmd;
    req_if.seed       = seed;
    req_if.range_low  = lo;
    req_if.range_high = hi;
    req_if.valid      = 1'b1;
    // ready is read at the edge, before the block updates it
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic offer_range(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
    offer(CMD_RANGE, $urandom, lo, hi);
  endtask

  // one random request; counted tells whether the block does anything with it
  task automatic random_request(output bit counted);
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    int                roll;
    roll    = $urandom_range(99);
    counted = 1'b1;
    if (roll < 3) begin
      offer(CMD_RESEED, $urandom, $urandom, $urandom);
    end else if (roll < 5) begin
      // unused code, ignored by the block
      offer(CMD_UNUSED, $urandom, $urandom, $urandom);
      counted = 1'b0;
    end else if (roll < 50) begin
      offer(CMD_RAW, $urandom, $urandom, $urandom);
    end else begin
      lo = $urandom;
      case ($urandom_range(3))
        // fully random bounds, about half of them empty
        0: hi = $urandom;
        // narrow spans, may wrap past the top and turn empty
        1: hi = lo + $urandom_range(1, 1000);
        // spans just over half the word range: heavy rejection
        2: begin
          lo = 32'h8000_0000 | ($urandom % 32'h7fff_fc00);
          hi = lo + 32'h8000_0000 + $urandom_range(0, 1000);
        end
        // power-of-two spans: nothing is rejected
        default: hi = lo + (32'd1 << $urandom_range(0, 31));
      endcase
      offer_range(lo, hi);
    end
  endtask

  task automatic random_phase(input int n);
    int sent;
    bit counted;
    sent = 0;
    while (sent < n) begin
      random_request(counted);
      if (counted)
        sent++;
    end
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    wait (results_due == 0);
    @(negedge clk);
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.cmd        = CMD_RAW;
    req_if.seed       = '0;
    req_if.range_low  = '0;
    req_if.range_high = '0;
    steady            = 1'b0;
    hold_off_req      = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // the table must be filled before any draw touches it
    offer(CMD_RESEED, 32'h0000_0000, 32'h0, 32'h0);
    offer(CMD_RAW, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer(CMD_RAW, 32'h0, 32'h0, 32'h0);
    // empty ranges: equal bounds, then high at the minimum below low at the maximum
    offer_range(32'h0000_1234, 32'h0000_1234);
    offer_range(32'h7fff_ffff, 32'h8000_0000);
    // widest span, whole signed range less one
    offer_range(32'h8000_0000, 32'h7fff_ffff);
    // single value span
    offer_range(32'd5, 32'd6);
    // span of half the range plus one, rejection close to one in two
    offer_range(32'hc000_0000, 32'h4000_0001);
    offer_range(32'hc000_0000, 32'h4000_0001);
    // negative bounds
    offer_range(-32'sd100, -32'sd3);
    // right at the top of the signed range
    offer_range(32'h7fff_fffe, 32'h7fff_ffff);
    offer(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    offer(CMD_RAW, 32'h0, 32'h0, 32'h0);
    offer(CMD_RESEED, 32'hffff_ffff, 32'h0, 32'h0);
    offer(CMD_RAW, 32'h0, 32'h0, 32'h0);
    offer_range(32'd0, 32'd256);
    offer(CMD_RESEED, GOLDEN, 32'h0, 32'h0);
    offer_range(32'h8000_0000, 32'h8000_0001);
    offer(CMD_RAW, 32'h0, 32'h0, 32'h0);

    // random traffic with gaps on both sides
    random_phase(600);

    // long hold-off on the result side while draws keep coming
    hold_off_req = 1'b1;
    repeat (20) offer(CMD_RAW, $urandom, $urandom, $urandom);
    wait_drained();

    // a long stretch back to back
    steady = 1'b1;
    random_phase(600);
    wait_drained();
    steady = 1'b0;

    random_phase(710);

    req_if.valid = 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
